[sv/phfrq_pkg.sv]
package phfrq_pkg;
    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_PAGE_BITS   = 12;
    localparam int unsigned ADDR_W = 40;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [2:0] PREFETCH_CMD = 3'd7;

    typedef enum logic [1:0] {
        CFG_FIFO_MODE = 2'd0,
        CFG_BUS_RATIO = 2'd1,
        CFG_DDR_SHIFT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE_SCAN,
        ST_ISSUE_DO,
        ST_RET_SCAN,
        ST_RETIRE,
        ST_DONE
    } t_state;

    // sequencer controls to the scan unit
    typedef struct packed {
        logic start;
        logic fifo_mode;
        logic ret_mode;
    } t_scan_ctl;
endpackage

[sv/phfrq_scan.sv]
// Shared scan unit: walks the ring one entry per cycle from the head.
module phfrq_scan #(
    parameter int unsigned QUEUE_DEPTH = phfrq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  phfrq_pkg::t_scan_ctl           i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_head,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_count,
    input  logic                           i_match,
    input  logic                           i_same,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_idx,
    output logic                           o_busy,
    output logic                           o_found,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_pick
);
    import phfrq_pkg::*;

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_left, n_left;
    logic          r_busy, n_busy, r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;

    assign o_idx = r_idx;
    assign o_busy = r_busy;
    assign o_found = r_found;
    assign o_pick = r_pick;

    // step one entry, stop on a decisive hit
    always_comb begin
        n_idx = r_idx; n_left = r_left; n_busy = r_busy;
        n_found = r_found; n_pick = r_pick;
        if (i_ctl.start) begin
            n_idx = i_head; n_left = i_count; n_busy = (i_count != '0);
            n_found = 1'b0; n_pick = i_head;
        end else if (r_busy) begin
            if (i_match) begin
                if (i_ctl.ret_mode) begin
                    n_found = 1'b1; n_pick = r_idx; n_busy = 1'b0;
                end else if (!r_found) begin
                    n_found = 1'b1; n_pick = r_idx;
                    if (i_ctl.fifo_mode || i_same) n_busy = 1'b0;
                end else if (i_same) begin
                    n_pick = r_idx; n_busy = 1'b0;
                end
            end
            if (n_busy) begin
                n_left = r_left - CW'(1);
                n_idx = (r_idx == IW'(QUEUE_DEPTH-1)) ? '0 : r_idx + IW'(1);
                if (r_left == CW'(1)) n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_found <= 1'b0;
        end else begin
            r_busy <= n_busy; r_found <= n_found;
        end
        r_idx <= n_idx; r_left <= n_left; r_pick <= n_pick;
    end
endmodule

[sv/page_hit_first_request_queue.sv]
// Open-page-first request ring. An enqueue passes through the done state
// to the result register. A bus tick walks the ring with one shared scan
// unit, one entry per cycle: once for issue selection and once for
// completion, plus issue, retire and result steps; a scan stops early on
// a decisive hit.
// Ready is low while an item is in work or its result waits.
module page_hit_first_request_queue #(
    parameter int unsigned QUEUE_DEPTH = phfrq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned PAGE_BITS   = phfrq_pkg::DEF_PAGE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [phfrq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [phfrq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [39:0] i_req_addr,
    input  logic [2:0]  i_req_cmd,
    input  logic [8:0]  i_req_line_bytes,
    input  logic        i_has_requester,
    input  logic [3:0]  i_miss_bank,
    input  logic [5:0]  i_miss_slot,
    input  logic [15:0] i_dram_latency,
    input  logic        i_fsb_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic        o_issue_valid,
    output logic [39:0] o_issue_addr,
    output logic [2:0]  o_issue_cmd,
    output logic [8:0]  o_issue_line_bytes,
    output logic        o_fill_valid,
    output logic [3:0]  o_fill_bank,
    output logic [5:0]  o_fill_slot,
    output logic [8:0]  o_fill_beats,
    output logic        o_fill_is_prefetch,
    output logic        o_retired
);
    import phfrq_pkg::*;

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);
    localparam int unsigned PW = ADDR_W - PAGE_BITS;

    // configuration
    logic       r_fifo_mode;
    logic [6:0] r_bus_ratio;
    logic [1:0] r_ddr_shift;
    logic [TIME_W-1:0] w_ratio;
    assign w_ratio = (r_bus_ratio == '0) ? TIME_W'(1) : TIME_W'(r_bus_ratio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_mode <= 1'b0; r_bus_ratio <= 7'd1; r_ddr_shift <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIFO_MODE: r_fifo_mode <= i_cfg_data[0];
                CFG_BUS_RATIO: r_bus_ratio <= i_cfg_data[6:0];
                CFG_DDR_SHIFT: r_ddr_shift <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // entry storage
    logic [QUEUE_DEPTH-1:0] r_ev, r_es, r_er;
    logic [ADDR_W-1:0] r_addr [QUEUE_DEPTH];
    logic [2:0]        r_cmd  [QUEUE_DEPTH];
    logic [8:0]        r_lb   [QUEUE_DEPTH];
    logic [10:0]       r_rq   [QUEUE_DEPTH];
    logic [TIME_W-1:0] r_fin  [QUEUE_DEPTH];

    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_occ;
    logic [PW-1:0] r_open;
    logic [TIME_W-1:0] r_now, r_next_free;

    // latched item
    logic        r_op, r_busfree;
    logic [15:0] r_lat;

    t_state r_state, n_state;
    t_scan_ctl w_ctl;
    logic [IW-1:0] w_idx, w_pick;
    logic w_busy, w_found, w_match, w_same;

    // result register
    logic r_ov, r_acc, r_iv, r_fv, r_ret;
    logic [39:0] r_ia; logic [2:0] r_ic; logic [8:0] r_il;
    logic [3:0] r_fb; logic [5:0] r_fs; logic [8:0] r_fbt; logic r_fp;

    assign o_ready = (r_state == ST_IDLE) && !r_ov;
    logic w_take;
    assign w_take = i_valid && o_ready;

    // per-entry test at the scan position
    always_comb begin
        w_same = (r_addr[w_idx][ADDR_W-1:PAGE_BITS] == r_open);
        if (r_state == ST_RET_SCAN)
            w_match = r_es[w_idx] && !r_er[w_idx] && (r_fin[w_idx] <= r_now) &&
                      (!r_rq[w_idx][10] || r_busfree);
        else
            w_match = !r_es[w_idx];
    end

    // only a returned entry with requester stops the completion scan
    logic w_silent;
    assign w_silent = (r_state == ST_RET_SCAN) && w_busy && w_match && !r_rq[w_idx][10];

    phfrq_scan #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_scan (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_head(r_head), .i_count(r_occ),
        .i_match(w_match && !w_silent), .i_same(w_same), .o_idx(w_idx),
        .o_busy(w_busy), .o_found(w_found), .o_pick(w_pick)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_take) n_state = i_opcode ? ST_ISSUE_SCAN : ST_DONE;
            ST_ISSUE_SCAN: if (!w_busy && !w_ctl.start) n_state = ST_ISSUE_DO;
            ST_ISSUE_DO: n_state = ST_RET_SCAN;
            ST_RET_SCAN: if (!w_busy && !w_ctl.start) n_state = ST_RETIRE;
            ST_RETIRE: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // scan controls; start pulses on entry to each scan
    logic r_started;
    always_comb begin
        w_ctl.fifo_mode = r_fifo_mode;
        w_ctl.ret_mode = (r_state == ST_RET_SCAN);
        w_ctl.start = ((r_state == ST_ISSUE_SCAN) || (r_state == ST_RET_SCAN)) && !r_started;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            r_started <= (n_state == r_state) && (w_ctl.start || r_started);
        end
    end

    logic w_do_issue;
    assign w_do_issue = (r_occ != '0) && (r_next_free <= r_now) && w_found;

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0; r_es <= '0; r_er <= '0;
            r_head <= '0; r_tail <= '0; r_occ <= '0;
            r_open <= '0; r_now <= '0; r_next_free <= '0; r_ov <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_ov <= 1'b0;
            if (w_take) begin
                r_op <= i_opcode; r_lat <= i_dram_latency; r_busfree <= i_fsb_free;
                {r_acc, r_iv, r_fv, r_ret} <= '0;
                r_ia <= '0; r_ic <= '0; r_il <= '0;
                r_fb <= '0; r_fs <= '0; r_fbt <= '0; r_fp <= 1'b0;
                if (!i_opcode && (r_occ < CW'(QUEUE_DEPTH))) begin
                    r_ev[r_tail] <= 1'b1; r_es[r_tail] <= 1'b0; r_er[r_tail] <= 1'b0;
                    r_addr[r_tail] <= i_req_addr; r_cmd[r_tail] <= i_req_cmd;
                    r_lb[r_tail] <= i_req_line_bytes;
                    r_rq[r_tail] <= {i_has_requester, i_miss_bank, i_miss_slot};
                    r_fin[r_tail] <= '0;
                    r_occ <= r_occ + CW'(1);
                    r_tail <= (r_tail == IW'(QUEUE_DEPTH-1)) ? '0 : r_tail + IW'(1);
                    r_acc <= 1'b1;
                end
            end
            if (r_state == ST_ISSUE_DO && w_do_issue) begin
                r_es[w_pick] <= 1'b1;
                r_fin[w_pick] <= r_now + TIME_W'(r_lat);
                r_open <= r_addr[w_pick][ADDR_W-1:PAGE_BITS];
                r_next_free <= r_now + w_ratio;
                r_iv <= 1'b1; r_ia <= r_addr[w_pick];
                r_ic <= r_cmd[w_pick]; r_il <= r_lb[w_pick];
            end
            // silent writebacks return as the scan passes them
            if (w_silent) r_er[w_idx] <= 1'b1;
            if (r_state == ST_RETIRE && w_found) begin
                r_er[w_pick] <= 1'b1;
                r_fv <= 1'b1; r_fb <= r_rq[w_pick][9:6]; r_fs <= r_rq[w_pick][5:0];
                r_fbt <= r_lb[w_pick] >> r_ddr_shift;
                r_fp <= (r_cmd[w_pick] == PREFETCH_CMD);
            end
            if (r_state == ST_DONE) begin
                r_ov <= 1'b1;
                if (r_op) begin
                    r_now <= r_now + w_ratio;
                    if (r_ev[r_head] && r_er[r_head]) begin
                        r_ev[r_head] <= 1'b0; r_es[r_head] <= 1'b0;
                        r_er[r_head] <= 1'b0;
                        r_occ <= r_occ - CW'(1);
                        r_head <= (r_head == IW'(QUEUE_DEPTH-1)) ? '0 : r_head + IW'(1);
                        r_ret <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_accepted = r_acc;
    assign o_issue_valid = r_iv;
    assign o_issue_addr = r_ia;
    assign o_issue_cmd = r_ic;
    assign o_issue_line_bytes = r_il;
    assign o_fill_valid = r_fv;
    assign o_fill_bank = r_fb;
    assign o_fill_slot = r_fs;
    assign o_fill_beats = r_fbt;
    assign o_fill_is_prefetch = r_fp;
    assign o_retired = r_ret;

    // occupancy never exceeds the ring depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH)) else $error("occupancy overflow");
    // no enqueue result carries tick fields
    a_enq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> !(o_issue_valid || o_fill_valid || o_retired))
        else $error("enqueue result with tick fields");
    // ring empty means no valid entry
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_ev == '0)) else $error("stale valid entry");
endmodule
